[hdl/sirp_pkg.sv]
// Shared types and constants for the step interval from ramp position unit.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package sirp_pkg;

   // Field widths fixed by the interface.
   localparam int STEP_WIDTH   = 32;
   localparam int ACCEL_WIDTH  = 20;
   localparam int PERIOD_WIDTH = 32;

   // Divisor k = 2*s*a: a 32 by 20 bit product, doubled.
   localparam int K_WIDTH = STEP_WIDTH + ACCEL_WIDTH + 1;

   // Defaults for the top level parameter and the acceleration register.
   localparam int                     TICKS_PER_SECOND_DEFAULT = 16000000;
   localparam logic [ACCEL_WIDTH-1:0] ACCEL_RESET              = 20'd1000;

   // Control that travels with each word through the pipeline.
   typedef struct packed {
      logic valid;
      logic sat;
   } sirp_ctl_type;

endpackage

[hdl/sirp_mult.sv]
// Entry stage: forms the divisor k = 2*s*a and flags the saturating cases.
// Depends on sirp_pkg.
`timescale 1ns / 1ps

module sirp_mult (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [sirp_pkg::STEP_WIDTH-1:0]      in_step,
   input  logic [sirp_pkg::ACCEL_WIDTH-1:0]     in_accel,
   output sirp_pkg::sirp_ctl_type               out_ctl,
   output logic [sirp_pkg::K_WIDTH-1:0]         out_k
);
   import sirp_pkg::*;

   localparam int PROD_WIDTH = STEP_WIDTH + ACCEL_WIDTH;

   logic [PROD_WIDTH-1:0] prod_in;
   logic [K_WIDTH-1:0]    k_ff;
   sirp_ctl_type          ctl_in;
   sirp_ctl_type          ctl_ff;

   // One 32 by 20 bit multiply; the doubling is a wire shift.
   assign prod_in = PROD_WIDTH'(in_step) * PROD_WIDTH'(in_accel);

   // A zero step count or zero acceleration saturates the period.
   assign ctl_in.valid = in_valid;
   assign ctl_in.sat   = (in_step == '0) || (in_accel == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= {prod_in, 1'b0};
   end

   assign out_ctl = ctl_ff;
   assign out_k   = k_ff;

endmodule

[hdl/sirp_divider.sv]
// Pipelined restoring divider: the constant TICKS_PER_SECOND^2 over k,
// one quotient bit per stage. Depends on sirp_pkg.
`timescale 1ns / 1ps

module sirp_divider #(
   parameter int TICKS_PER_SECOND = sirp_pkg::TICKS_PER_SECOND_DEFAULT,
   parameter int Q_WIDTH          = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sirp_pkg::sirp_ctl_type            in_ctl,
   input  logic [sirp_pkg::K_WIDTH-1:0]      in_k,
   output sirp_pkg::sirp_ctl_type            out_ctl,
   output logic [Q_WIDTH-1:0]                out_q
);
   import sirp_pkg::*;

   localparam longint unsigned TSQ = longint'(TICKS_PER_SECOND) * longint'(TICKS_PER_SECOND);
   localparam logic [Q_WIDTH-1:0] DIVIDEND = Q_WIDTH'(TSQ);

   logic [K_WIDTH-1:0] rem_ff [Q_WIDTH];
   logic [K_WIDTH-1:0] k_ff   [Q_WIDTH];
   logic [Q_WIDTH-1:0] q_ff   [Q_WIDTH];
   sirp_ctl_type       ctl_ff [Q_WIDTH];

   for (genvar i = 0; i < Q_WIDTH; i++) begin : g_stage
      logic [K_WIDTH-1:0] rem_prev;
      logic [K_WIDTH-1:0] k_prev;
      logic [Q_WIDTH-1:0] q_prev;
      sirp_ctl_type       ctl_prev;
      logic [K_WIDTH:0]   shifted;
      logic               take;
      logic [K_WIDTH-1:0] rem_in;
      logic [Q_WIDTH-1:0] q_in;

      // Stage inputs come from the entry stage or the stage before.
      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign k_prev   = in_k;
         assign q_prev   = '0;
         assign ctl_prev = in_ctl;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign k_prev   = k_ff[i-1];
         assign q_prev   = q_ff[i-1];
         assign ctl_prev = ctl_ff[i-1];
      end

      // Bring down the next dividend bit and try a subtraction.
      // The partial remainder stays below k, so it fits K_WIDTH bits.
      assign shifted = {rem_prev, DIVIDEND[Q_WIDTH-1-i]};
      assign take    = shifted >= {1'b0, k_prev};
      assign rem_in  = take ? K_WIDTH'(shifted - {1'b0, k_prev}) : K_WIDTH'(shifted);
      assign q_in    = {q_prev[Q_WIDTH-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else begin
            ctl_ff[i] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         k_ff[i]   <= k_prev;
         q_ff[i]   <= q_in;
      end
   end

   assign out_ctl = ctl_ff[Q_WIDTH-1];
   assign out_q   = q_ff[Q_WIDTH-1];

endmodule

[hdl/sirp_sqrt.sv]
// Pipelined integer square root, two radicand bits and one root bit per stage.
// Depends on sirp_pkg.
`timescale 1ns / 1ps

module sirp_sqrt #(
   parameter int Q_WIDTH = 48,
   parameter int R_WIDTH = (Q_WIDTH + 1) / 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sirp_pkg::sirp_ctl_type       in_ctl,
   input  logic [Q_WIDTH-1:0]           in_q,
   output sirp_pkg::sirp_ctl_type       out_ctl,
   output logic [R_WIDTH-1:0]           out_root
);
   import sirp_pkg::*;

   localparam int X_WIDTH = 2 * R_WIDTH;

   logic [X_WIDTH-1:0] x_ff    [R_WIDTH];
   logic [R_WIDTH:0]   rem_ff  [R_WIDTH];
   logic [R_WIDTH-1:0] root_ff [R_WIDTH];
   sirp_ctl_type       ctl_ff  [R_WIDTH];

   for (genvar j = 0; j < R_WIDTH; j++) begin : g_stage
      logic [X_WIDTH-1:0] x_prev;
      logic [R_WIDTH:0]   rem_prev;
      logic [R_WIDTH-1:0] root_prev;
      sirp_ctl_type       ctl_prev;
      logic [R_WIDTH+2:0] shifted;
      logic [R_WIDTH+2:0] trial;
      logic               take;
      logic [R_WIDTH:0]   rem_in;
      logic [R_WIDTH-1:0] root_in;
      logic [X_WIDTH-1:0] x_in;

      if (j == 0) begin : g_first
         assign x_prev    = X_WIDTH'(in_q);
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign ctl_prev  = in_ctl;
      end else begin : g_next
         assign x_prev    = x_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign ctl_prev  = ctl_ff[j-1];
      end

      // Bring down the next bit pair and test against 4*root + 1.
      // The remainder never exceeds twice the root, so R_WIDTH+1 bits hold it.
      assign shifted = {rem_prev, x_prev[X_WIDTH-1 -: 2]};
      assign trial   = {1'b0, root_prev, 2'b01};
      assign take    = shifted >= trial;
      assign rem_in  = take ? (R_WIDTH+1)'(shifted - trial) : (R_WIDTH+1)'(shifted);
      assign root_in = {root_prev[R_WIDTH-2:0], take};
      assign x_in    = {x_prev[X_WIDTH-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else begin
            ctl_ff[j] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[j]    <= x_in;
         rem_ff[j]  <= rem_in;
         root_ff[j] <= root_in;
      end
   end

   assign out_ctl  = ctl_ff[R_WIDTH-1];
   assign out_root = root_ff[R_WIDTH-1];

endmodule

[hdl/step_interval_from_ramp_position_unit.sv]
// One multiply stage, one divider stage per quotient bit (Q bits, the bit count of
// TICKS_PER_SECOND^2) and one root stage per root bit (R = (Q+1)/2 bits).
// Throughput: one word per cycle, busy stays low.
// Reset clears every pipeline valid bit, so words in flight are dropped, and sets the
// acceleration register to 1000. Results cannot be stalled and appear for one cycle.
// Depends on sirp_pkg, sirp_mult, sirp_divider and sirp_sqrt.
`timescale 1ns / 1ps

module step_interval_from_ramp_position_unit #(
   parameter int TICKS_PER_SECOND = sirp_pkg::TICKS_PER_SECOND_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sirp_pkg::STEP_WIDTH-1:0]     req_step_count,
   output logic                                rsp_valid,
   output logic [sirp_pkg::PERIOD_WIDTH-1:0]   rsp_period_ticks,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sirp_pkg::ACCEL_WIDTH-1:0]    csr_data
);
   import sirp_pkg::*;

   localparam longint unsigned TSQ = longint'(TICKS_PER_SECOND) * longint'(TICKS_PER_SECOND);
   localparam int Q_WIDTH = $clog2(TSQ + 1);
   localparam int R_WIDTH = (Q_WIDTH + 1) / 2;
   localparam int LATENCY = 1 + Q_WIDTH + R_WIDTH;

   logic [ACCEL_WIDTH-1:0] accel_ff;
   logic                   accept;
   sirp_ctl_type           mult_ctl;
   logic [K_WIDTH-1:0]     mult_k;
   sirp_ctl_type           div_ctl;
   logic [Q_WIDTH-1:0]     div_q;
   sirp_ctl_type           root_ctl;
   logic [R_WIDTH-1:0]     root;

   // The pipeline never stalls, so a word is taken whenever start is high.
   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Acceleration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= ACCEL_RESET;
      end else if (csr_valid && csr_ready) begin
         accel_ff <= csr_data;
      end
   end

   sirp_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_step  (req_step_count),
      .in_accel (accel_ff),
      .out_ctl  (mult_ctl),
      .out_k    (mult_k)
   );

   sirp_divider #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .Q_WIDTH          (Q_WIDTH)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (mult_ctl),
      .in_k    (mult_k),
      .out_ctl (div_ctl),
      .out_q   (div_q)
   );

   sirp_sqrt #(
      .Q_WIDTH (Q_WIDTH),
      .R_WIDTH (R_WIDTH)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (div_ctl),
      .in_q     (div_q),
      .out_ctl  (root_ctl),
      .out_root (root)
   );

   // Saturated words override whatever the divider made of a zero divisor.
   assign rsp_valid        = root_ctl.valid;
   assign rsp_saturated    = root_ctl.sat;
   assign rsp_period_ticks = root_ctl.sat ? '1 : PERIOD_WIDTH'(root);

   // Every result strobe traces back to an accepted word.
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without an accepted word");

   // A zero step count comes out saturated after the pipeline latency.
   a_zero_step_sat: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_step_count == '0)) |-> ##LATENCY (rsp_valid && rsp_saturated))
      else $error("zero step count did not saturate");

   // A saturated result always carries the all-ones period.
   a_sat_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_period_ticks == '1))
      else $error("saturated result without all-ones period");

   // An ordinary period never exceeds the root width.
   a_period_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_saturated) |-> ((rsp_period_ticks >> R_WIDTH) == '0))
      else $error("period wider than the root");

endmodule

[bench/step_interval_from_ramp_position_unit_tb.sv]
// Self-checking bench for the step interval from ramp position unit.
// It predicts each period from the step count and the acceleration. It depends on sirp_pkg
// and on step_interval_from_ramp_position_unit.
`timescale 1ns / 1ps

module step_interval_from_ramp_position_unit_tb;

   import sirp_pkg::*;

   localparam int          TICKS         = TICKS_PER_SECOND_DEFAULT;
   localparam logic [63:0] TICKS_SQUARED = 64'(TICKS) * 64'(TICKS);
   localparam int          RESET_CYCLES  = 12;
   localparam int          SETTLE_CYCLES = 100;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          PHASE_ITEMS   = 135;

   // One expected result word.
   typedef struct {
      logic [PERIOD_WIDTH-1:0] period;
      logic                    sat;
   } period_result_type;

   // Predicts the period of each accepted step count and checks results in order.
   class ramp_period_scoreboard;
      logic [ACCEL_WIDTH-1:0] accel;
      period_result_type      expected_periods[$];
      int unsigned            mismatches;

      function new();
         accel      = ACCEL_RESET;
         mismatches = 0;
      endfunction

      function void set_accel(logic [ACCEL_WIDTH-1:0] value);
         accel = value;
      endfunction

      // Largest root whose square does not exceed x, built one bit at a time from the top.
      function logic [31:0] floor_sqrt(logic [63:0] x);
         logic [31:0] root;
         logic [31:0] trial;
         logic [63:0] square;
         root = '0;
         for (int i = 31; i >= 0; i--) begin
            trial  = root | (32'd1 << i);
            square = {32'd0, trial} * {32'd0, trial};
            if (square <= x) root = trial;
         end
         return root;
      endfunction

      function void note_step(logic [STEP_WIDTH-1:0] step);
         logic [63:0]       divisor;
         logic [63:0]       quotient;
         period_result_type result;
         // A zero step count or a zero acceleration saturates the period.
         if (step == '0 || accel == '0) begin
            result.period = '1;
            result.sat    = 1'b1;
         end else begin
            divisor       = ({32'd0, step} * {44'd0, accel}) << 1;
            quotient      = TICKS_SQUARED / divisor;
            result.period = floor_sqrt(quotient);
            result.sat    = 1'b0;
         end
         expected_periods.push_back(result);
      endfunction

      function void check_period(logic [PERIOD_WIDTH-1:0] period, logic sat);
         period_result_type want;
         if (expected_periods.size() == 0) begin
            $error("unexpected result word: period_ticks %0d saturated %0d", period, sat);
            mismatches++;
            return;
         end
         want = expected_periods.pop_front();
         if (period !== want.period) begin
            $error("period_ticks: expected %0d, actual %0d", want.period, period);
            mismatches++;
         end
         if (sat !== want.sat) begin
            $error("saturated: expected %0d, actual %0d", want.sat, sat);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_periods.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [STEP_WIDTH-1:0]   req_step_count = '0;
   logic                    rsp_valid;
   logic [PERIOD_WIDTH-1:0] rsp_period_ticks;
   logic                    rsp_saturated;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [ACCEL_WIDTH-1:0]  csr_data = '0;

   int unsigned             cycle_count = 0;

   ramp_period_scoreboard period_board = new();

   step_interval_from_ramp_position_unit #(
      .TICKS_PER_SECOND(TICKS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_step_count  (req_step_count),
      .rsp_valid       (rsp_valid),
      .rsp_period_ticks(rsp_period_ticks),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Every result word is taken in the cycle it is shown.
   always @(posedge clock) begin
      if (!reset && rsp_valid) period_board.check_period(rsp_period_ticks, rsp_saturated);
   end

   // Watchdog against a hung pipeline.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offers one step count after an idle gap and returns at the edge that accepts it.
   task automatic send_step(input logic [STEP_WIDTH-1:0] step, input int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_step_count <= step;
      do @(posedge clock); while (busy);
      period_board.note_step(step);
   endtask

   // Holds the sender off until every expected word has come back.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (period_board.pending() != 0);
   endtask

   task automatic write_accel(input logic [ACCEL_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      period_board.set_accel(value);
   endtask

   // Mix of zero, short ramps, mid ranges, full width and random magnitudes.
   function automatic logic [STEP_WIDTH-1:0] random_step();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return '0;
         1, 2, 3: return $urandom_range(1, 1000);
         4, 5: return $urandom_range(1, 1 << 20);
         6, 7, 8: return $urandom;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic run_random_phase(input logic [ACCEL_WIDTH-1:0] accel, input bit back_to_back);
      wait_drained();
      write_accel(accel);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         send_step(random_step(), back_to_back ? 0 : $urandom_range(0, 8));
      end
   endtask

   initial begin
      logic [ACCEL_WIDTH-1:0] phase_accel[8];
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset acceleration: zero, smallest, largest and bit patterns.
      send_step(32'd0, 0);
      send_step(32'd1, 0);
      send_step(32'd2, 3);
      send_step(32'hFFFF_FFFF, 0);
      send_step(32'h8000_0000, 1);
      send_step(32'h7FFF_FFFF, 0);
      send_step(32'd1000, 2);
      send_step(32'hAAAA_AAAA, 0);
      send_step(32'h5555_5555, 0);
      send_step(32'd128000, 5);

      // Zero acceleration saturates every word.
      wait_drained();
      write_accel('0);
      send_step(32'd1, 0);
      send_step(32'hFFFF_FFFF, 0);
      send_step(32'd0, 0);

      // Largest register value gives the largest divisor.
      wait_drained();
      write_accel('1);
      send_step(32'hFFFF_FFFF, 0);
      send_step(32'd1, 2);
      send_step(32'h1234_5678, 0);

      // Smallest nonzero acceleration gives the longest periods.
      wait_drained();
      write_accel(20'd1);
      send_step(32'd1, 0);
      send_step(32'hFFFF_FFFF, 0);
      send_step(32'h8000_0000, 0);

      // Random phases, each at its own acceleration.
      phase_accel[0] = 20'd1;
      phase_accel[1] = '1;
      phase_accel[2] = 20'd1000000;
      phase_accel[3] = ACCEL_WIDTH'($urandom);
      phase_accel[4] = ACCEL_WIDTH'($urandom_range(1, 5000));
      phase_accel[5] = '0;
      phase_accel[6] = 20'd2;
      phase_accel[7] = ACCEL_RESET;
      for (int p = 0; p < 8; p++) begin
         run_random_phase(phase_accel[p], (p == 3 || p == 6));
      end

      // Let the pipeline empty, then watch for stray words.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (period_board.pending() != 0) begin
         $error("%0d expected words never arrived", period_board.pending());
      end
      if (period_board.mismatches == 0 && period_board.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/sirp_pkg.sv
hdl/sirp_mult.sv
hdl/sirp_divider.sv
hdl/sirp_sqrt.sv
hdl/step_interval_from_ramp_position_unit.sv
bench/step_interval_from_ramp_position_unit_tb.sv
